// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/iir_df1_pkg.sv
// ----------------------------------------------------------------------------
// iir_df1_pkg
// Types and constants of the direct form I biquad: beat structs, register
// indexes, coefficient reset values and the sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iir_df1_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int FRAC_W   = 20;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  // Five products plus rounding bias need three guard bits
  localparam int ACC_W    = PROD_W + 3;
  localparam int INDEX_W  = 3;
  localparam int STEP_W   = 3;

  // Register indexes on the configuration port
  localparam logic [INDEX_W-1:0] REG_B0 = 3'd0;
  localparam logic [INDEX_W-1:0] REG_B1 = 3'd1;
  localparam logic [INDEX_W-1:0] REG_B2 = 3'd2;
  localparam logic [INDEX_W-1:0] REG_A1 = 3'd3;
  localparam logic [INDEX_W-1:0] REG_A2 = 3'd4;

  // Coefficient reset values, Q4.20
  localparam logic signed [COEF_W-1:0] B0_RESET = 24'sd1048576;
  localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

  // Multiply-accumulate order: tap by tap, feedforward and feedback interleaved
  localparam logic [STEP_W-1:0] STEP_B0 = 3'd0;
  localparam logic [STEP_W-1:0] STEP_A1 = 3'd1;
  localparam logic [STEP_W-1:0] STEP_B1 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_A2 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_B2 = 3'd4;

  // Round half up: bias of one half LSB of the output
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 43'sd524288;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;

  localparam logic ACTION_FILTER = 1'b0;
  localparam logic ACTION_CLEAR  = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND
  } state_t;

endpackage

// File: hw/rtl/iir_biquad_direct_form_one_unit.sv
// ----------------------------------------------------------------------------
// iir_biquad_direct_form_one_unit
// Direct form I IIR filter with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Each filter beat is accepted in the idle state, then runs one multiply per tap
// on the single 24x16 multiplier, adds the last product in the drain state, and
// rounds and saturates in the round state, which waits for the output register
// to be free. The input is not ready again until the result has been loaded
// into the output register, which holds it until taken. A clear beat zeroes the
// histories and gives no result. Coefficients are signed Q4.20; the user must
// write them only while the filter is idle, as the block does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iir_biquad_direct_form_one_unit #(
  parameter int FEEDFORWARD_TAPS = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  iir_df1_pkg::in_item_t               in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output iir_df1_pkg::out_item_t              out_data,
  input  logic                                cfg_en,
  input  logic [iir_df1_pkg::INDEX_W-1:0]     cfg_index,
  input  logic [iir_df1_pkg::COEF_W-1:0]      cfg_data
);

  localparam int N_STEPS = 2 * FEEDFORWARD_TAPS - 1;
  localparam logic [iir_df1_pkg::STEP_W-1:0] LAST_STEP =
    iir_df1_pkg::STEP_W'(N_STEPS - 1);

  // Coefficients
  logic signed [iir_df1_pkg::COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  // Histories and current sample
  logic signed [iir_df1_pkg::SAMPLE_W-1:0] x_cur;
  logic signed [iir_df1_pkg::SAMPLE_W-1:0] hx [2];
  logic signed [iir_df1_pkg::SAMPLE_W-1:0] hy [2];

  // Sequencer and datapath
  iir_df1_pkg::state_t                     state, state_next;
  logic [iir_df1_pkg::STEP_W-1:0]          step;
  logic signed [iir_df1_pkg::COEF_W-1:0]   coef_sel;
  logic signed [iir_df1_pkg::SAMPLE_W-1:0] samp_sel;
  logic                                    sub_sel;
  logic signed [iir_df1_pkg::PROD_W-1:0]   mult;
  logic signed [iir_df1_pkg::PROD_W-1:0]   prod;
  logic                                    prod_sub;
  logic                                    prod_vld;
  logic signed [iir_df1_pkg::ACC_W-1:0]    acc;

  logic in_fire, filter_fire, clear_fire;
  logic mac_en, drain_en, round_en, out_free;

  logic signed [iir_df1_pkg::SAMPLE_W-1:0] res_val;
  logic                                    res_sat;
  logic                                    over_range;

  assign in_fire     = in_valid && in_ready;
  assign filter_fire = in_fire && (in_data.action == iir_df1_pkg::ACTION_FILTER);
  assign clear_fire  = in_fire && (in_data.action == iir_df1_pkg::ACTION_CLEAR);
  assign out_free    = !out_valid || out_ready;

  // Write coefficients
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= iir_df1_pkg::B0_RESET;
      coef_b1 <= iir_df1_pkg::COEF_ZERO;
      coef_b2 <= iir_df1_pkg::COEF_ZERO;
      coef_a1 <= iir_df1_pkg::COEF_ZERO;
      coef_a2 <= iir_df1_pkg::COEF_ZERO;
    end else if (cfg_en) begin
      case (cfg_index)
        iir_df1_pkg::REG_B0: coef_b0 <= cfg_data;
        iir_df1_pkg::REG_B1: coef_b1 <= cfg_data;
        iir_df1_pkg::REG_B2: coef_b2 <= cfg_data;
        iir_df1_pkg::REG_A1: coef_a1 <= cfg_data;
        iir_df1_pkg::REG_A2: coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      iir_df1_pkg::ST_IDLE:  if (filter_fire) state_next = iir_df1_pkg::ST_MAC;
      iir_df1_pkg::ST_MAC:   if (step == LAST_STEP) state_next = iir_df1_pkg::ST_DRAIN;
      iir_df1_pkg::ST_DRAIN: state_next = iir_df1_pkg::ST_ROUND;
      iir_df1_pkg::ST_ROUND: if (out_free) state_next = iir_df1_pkg::ST_IDLE;
      default:               state_next = iir_df1_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    mac_en   = 1'b0;
    drain_en = 1'b0;
    round_en = 1'b0;
    case (state)
      iir_df1_pkg::ST_IDLE:  in_ready = 1'b1;
      iir_df1_pkg::ST_MAC:   mac_en   = 1'b1;
      iir_df1_pkg::ST_DRAIN: drain_en = 1'b1;
      iir_df1_pkg::ST_ROUND: round_en = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iir_df1_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= iir_df1_pkg::STEP_B0;
    end else if (filter_fire) begin
      step <= iir_df1_pkg::STEP_B0;
    end else if (mac_en) begin
      step <= step + 1'b1;
    end
  end

  // Select coefficient and operand for this step
  always_comb begin
    coef_sel = iir_df1_pkg::COEF_ZERO;
    samp_sel = x_cur;
    sub_sel  = 1'b0;
    case (step)
      iir_df1_pkg::STEP_B0: begin
        coef_sel = coef_b0;
        samp_sel = x_cur;
      end
      iir_df1_pkg::STEP_A1: begin
        coef_sel = coef_a1;
        samp_sel = hy[0];
        sub_sel  = 1'b1;
      end
      iir_df1_pkg::STEP_B1: begin
        coef_sel = coef_b1;
        samp_sel = hx[0];
      end
      iir_df1_pkg::STEP_A2: begin
        coef_sel = coef_a2;
        samp_sel = hy[1];
        sub_sel  = 1'b1;
      end
      iir_df1_pkg::STEP_B2: begin
        coef_sel = coef_b2;
        samp_sel = hx[1];
      end
      default: ;
    endcase
  end

  assign mult = coef_sel * samp_sel;

  // Register each product, then fold it into the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= mac_en;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= mult;
    prod_sub <= sub_sel;
    if (filter_fire) begin
      acc <= iir_df1_pkg::ROUND_BIAS;
    end else if (prod_vld && (mac_en || drain_en)) begin
      if (prod_sub) begin
        acc <= acc - iir_df1_pkg::ACC_W'(prod);
      end else begin
        acc <= acc + iir_df1_pkg::ACC_W'(prod);
      end
    end
  end

  // Round (bias already in) and saturate
  assign over_range = (acc[iir_df1_pkg::ACC_W-1:iir_df1_pkg::FRAC_W+iir_df1_pkg::SAMPLE_W-1]
                       != {(iir_df1_pkg::ACC_W-iir_df1_pkg::FRAC_W-iir_df1_pkg::SAMPLE_W+1)
                           {acc[iir_df1_pkg::FRAC_W+iir_df1_pkg::SAMPLE_W-1]}});

  always_comb begin
    res_sat = over_range;
    if (!over_range) begin
      res_val = acc[iir_df1_pkg::FRAC_W+iir_df1_pkg::SAMPLE_W-1:iir_df1_pkg::FRAC_W];
    end else if (acc[iir_df1_pkg::ACC_W-1]) begin
      res_val = iir_df1_pkg::SAMPLE_MIN;
    end else begin
      res_val = iir_df1_pkg::SAMPLE_MAX;
    end
  end

  // Latch the new sample; shift or clear the histories
  always_ff @(posedge clk) begin
    if (rst) begin
      hx[0] <= '0;
      hx[1] <= '0;
      hy[0] <= '0;
      hy[1] <= '0;
    end else if (clear_fire) begin
      hx[0] <= '0;
      hx[1] <= '0;
      hy[0] <= '0;
      hy[1] <= '0;
    end else if (round_en) begin
      hx[1] <= hx[0];
      hx[0] <= x_cur;
      hy[1] <= hy[0];
      hy[0] <= res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (filter_fire) begin
      x_cur <= in_data.sample_in;
    end
  end

  // Output register: load on round, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (round_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (round_en) begin
      out_data.sample_out <= res_val;
      out_data.saturated  <= res_sat;
    end
  end

  // Checks
  `ASSERT_NEXT(a_filter_starts, clk, rst, filter_fire, (state == iir_df1_pkg::ST_MAC) && (acc == iir_df1_pkg::ROUND_BIAS) && (step == iir_df1_pkg::STEP_B0))
  `ASSERT_NEXT(a_last_tap_drains, clk, rst, (state == iir_df1_pkg::ST_MAC) && (step == LAST_STEP), (state == iir_df1_pkg::ST_DRAIN) && prod_vld)
  `ASSERT_NEXT(a_clear_zeroes, clk, rst, clear_fire, (hx[0] == '0) && (hx[1] == '0) && (hy[0] == '0) && (hy[1] == '0) && (state == iir_df1_pkg::ST_IDLE))
  `ASSERT_IMPL(a_sat_clamped, clk, rst, out_valid && out_data.saturated, (out_data.sample_out == iir_df1_pkg::SAMPLE_MAX) || (out_data.sample_out == iir_df1_pkg::SAMPLE_MIN))

endmodule
